// ===== src/pid_pkg.sv =====
// ----------------------------------------------------------------------------
// pid_pkg
// widths, fixed-point formats and register indexes of the pid regulator
// ----------------------------------------------------------------------------
package pid_pkg;

   // data and gains are signed Q16.16, error sum is signed Q32.16
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int ACC_WIDTH  = 48;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KP    = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KI_DT = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KD_DT = CSR_INDEX_WIDTH'(2);

   // the integral product is built from two partial products of the error sum
   localparam int SUM_SPLIT = ACC_WIDTH / 2;
   localparam int SUM_HI_W  = ACC_WIDTH - SUM_SPLIT;

   localparam int DIFF_W     = DATA_WIDTH + 1;
   localparam int PROD_P_W   = 2 * DATA_WIDTH;
   localparam int PROD_D_W   = DATA_WIDTH + DIFF_W;
   localparam int PROD_ILO_W = DATA_WIDTH + SUM_SPLIT + 1;
   localparam int PROD_IHI_W = DATA_WIDTH + SUM_HI_W;
   localparam int TOTAL_W    = DATA_WIDTH + ACC_WIDTH + 2;
   localparam int SHIFTED_W  = TOTAL_W - FRAC_BITS;

endpackage

// ===== src/pid_regulator_unit.sv =====
// ----------------------------------------------------------------------------
// pid_regulator_unit
// discrete pid regulator on signed Q16.16 error samples
// ----------------------------------------------------------------------------
// each request carries one error sample and a clear_integral flag; each one
// gives exactly one response with the saturated drive and a saturated flag
// that is set when the drive or the running error sum was clamped.
// a request is taken when req_valid is high and req_stall is low, a response
// leaves when rsp_valid is high and rsp_stall is low.
// from request to response, the error sum and the difference are formed on
// acceptance, the gain products in the next stage, their sum in the third,
// the shift and clamp into the output register last.
// throughput is one request per cycle while req_stall is low; the error sum and previous error are
// updated in the accept cycle, so consecutive requests see each other's state.
// when rsp_stall is held, the pipeline fills its empty stages and then raises
// req_stall; a waiting response does not block a request behind it.
// reset clears the gains, the error sum, the previous error and all valids.
// a csr write (index 0 kp, 1 ki_dt, 2 kd_dt) sets the gain and clears the
// error sum and previous error; other indexes are ignored. write only when
// no request is in flight.
// ----------------------------------------------------------------------------
module pid_regulator_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [pid_pkg::DATA_WIDTH-1:0] req_error,
   input  logic                                  req_clear_integral,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [pid_pkg::DATA_WIDTH-1:0] rsp_drive,
   output logic                                  rsp_saturated,
   input  logic                                  csr_write,
   input  logic [pid_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pid_pkg::DATA_WIDTH-1:0]        csr_wdata
);

   localparam int DW  = pid_pkg::DATA_WIDTH;
   localparam int AW  = pid_pkg::ACC_WIDTH;
   localparam int SPL = pid_pkg::SUM_SPLIT;

   // gains and loop state
   logic signed [DW-1:0] kp_ff, ki_dt_ff, kd_dt_ff;
   logic signed [AW-1:0] error_sum_ff, error_sum_in;
   logic signed [DW-1:0] previous_error_ff;
   logic                 sum_clamped_in;
   logic                 csr_hit;

   // stage 1
   logic                                s1_valid_ff;
   logic signed [DW-1:0]                s1_error_ff;
   logic signed [AW-1:0]                s1_sum_ff;
   logic signed [pid_pkg::DIFF_W-1:0]   s1_diff_ff, s1_diff_in;
   logic                                s1_sat_ff;

   // stage 2
   logic                                  s2_valid_ff;
   logic signed [pid_pkg::PROD_P_W-1:0]   s2_prod_p_ff, s2_prod_p_in;
   logic signed [pid_pkg::PROD_D_W-1:0]   s2_prod_d_ff, s2_prod_d_in;
   logic signed [pid_pkg::PROD_ILO_W-1:0] s2_prod_ilo_ff, s2_prod_ilo_in;
   logic signed [pid_pkg::PROD_IHI_W-1:0] s2_prod_ihi_ff, s2_prod_ihi_in;
   logic                                  s2_sat_ff;

   // stage 3
   logic                                  s3_valid_ff;
   logic signed [pid_pkg::TOTAL_W-1:0]    s3_total_ff, s3_total_in;
   logic                                  s3_sat_ff;

   // output register
   logic                                  rsp_valid_ff;
   logic signed [DW-1:0]                  rsp_drive_ff, rsp_drive_in;
   logic                                  rsp_sat_ff;
   logic                                  drive_clamped_in;

   logic ready_out, ready_s3, ready_s2, ready_s1, accept;

   logic signed [AW:0]                      sum_wide;
   logic signed [AW-1:0]                    sum_base;
   logic signed [pid_pkg::SHIFTED_W-1:0]    shifted;
   logic                                    shifted_hi_ones, shifted_hi_zeros;

   // flow control
   assign ready_out = !rsp_valid_ff || !rsp_stall;
   assign ready_s3  = !s3_valid_ff  || ready_out;
   assign ready_s2  = !s2_valid_ff  || ready_s3;
   assign ready_s1  = !s1_valid_ff  || ready_s2;
   assign req_stall = !ready_s1;
   assign accept    = req_valid && ready_s1;

   assign csr_hit = csr_write &&
                    (csr_index == pid_pkg::CSR_KP || csr_index == pid_pkg::CSR_KI_DT ||
                     csr_index == pid_pkg::CSR_KD_DT);

   // saturating error sum and error difference
   always_comb begin
      sum_base = req_clear_integral ? '0 : error_sum_ff;
      sum_wide = (AW+1)'(sum_base) + (AW+1)'(req_error);
      sum_clamped_in = sum_wide[AW] != sum_wide[AW-1];
      if (!sum_clamped_in) begin
         error_sum_in = sum_wide[AW-1:0];
      end else if (sum_wide[AW]) begin
         error_sum_in = {1'b1, {(AW-1){1'b0}}};
      end else begin
         error_sum_in = {1'b0, {(AW-1){1'b1}}};
      end
      s1_diff_in = pid_pkg::DIFF_W'(req_error) - pid_pkg::DIFF_W'(previous_error_ff);
   end

   // gain products, the integral one split in two halves of the sum
   always_comb begin
      s2_prod_p_in   = kp_ff * s1_error_ff;
      s2_prod_d_in   = kd_dt_ff * s1_diff_ff;
      s2_prod_ilo_in = ki_dt_ff * $signed({1'b0, s1_sum_ff[SPL-1:0]});
      s2_prod_ihi_in = ki_dt_ff * $signed(s1_sum_ff[AW-1:SPL]);
   end

   // sum of products
   always_comb begin
      s3_total_in = pid_pkg::TOTAL_W'(s2_prod_p_ff) + pid_pkg::TOTAL_W'(s2_prod_d_ff)
                  + pid_pkg::TOTAL_W'(s2_prod_ilo_ff)
                  + (pid_pkg::TOTAL_W'(s2_prod_ihi_ff) <<< SPL);
   end

   // drop fraction bits and clamp to the data width
   always_comb begin
      shifted          = s3_total_ff[pid_pkg::TOTAL_W-1:pid_pkg::FRAC_BITS];
      shifted_hi_ones  = &shifted[pid_pkg::SHIFTED_W-1:DW-1];
      shifted_hi_zeros = ~|shifted[pid_pkg::SHIFTED_W-1:DW-1];
      drive_clamped_in = !(shifted_hi_ones || shifted_hi_zeros);
      if (!drive_clamped_in) begin
         rsp_drive_in = shifted[DW-1:0];
      end else if (shifted[pid_pkg::SHIFTED_W-1]) begin
         rsp_drive_in = {1'b1, {(DW-1){1'b0}}};
      end else begin
         rsp_drive_in = {1'b0, {(DW-1){1'b1}}};
      end
   end

   // gains and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff             <= '0;
         ki_dt_ff          <= '0;
         kd_dt_ff          <= '0;
         error_sum_ff      <= '0;
         previous_error_ff <= '0;
      end else if (csr_hit) begin
         unique case (csr_index)
            pid_pkg::CSR_KP:    kp_ff    <= csr_wdata;
            pid_pkg::CSR_KI_DT: ki_dt_ff <= csr_wdata;
            pid_pkg::CSR_KD_DT: kd_dt_ff <= csr_wdata;
            default: ;
         endcase
         error_sum_ff      <= '0;
         previous_error_ff <= '0;
      end else if (accept) begin
         error_sum_ff      <= error_sum_in;
         previous_error_ff <= req_error;
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready_s1) begin
            s1_valid_ff <= req_valid;
         end
         if (ready_s2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (ready_s3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (ready_out) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_error_ff <= req_error;
         s1_sum_ff   <= error_sum_in;
         s1_diff_ff  <= s1_diff_in;
         s1_sat_ff   <= sum_clamped_in;
      end
      if (ready_s2 && s1_valid_ff) begin
         s2_prod_p_ff   <= s2_prod_p_in;
         s2_prod_d_ff   <= s2_prod_d_in;
         s2_prod_ilo_ff <= s2_prod_ilo_in;
         s2_prod_ihi_ff <= s2_prod_ihi_in;
         s2_sat_ff      <= s1_sat_ff;
      end
      if (ready_s3 && s2_valid_ff) begin
         s3_total_ff <= s3_total_in;
         s3_sat_ff   <= s2_sat_ff;
      end
      if (ready_out && s3_valid_ff) begin
         rsp_drive_ff <= rsp_drive_in;
         rsp_sat_ff   <= s3_sat_ff || drive_clamped_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

// ===== bench/pid_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_checker
// watches the request, response and csr ports of the pid regulator, predicts
// the drive and saturated flag of every accepted request from its own copy of
// the gains, error sum and previous error, and compares each accepted
// response in order against the oldest prediction
// ----------------------------------------------------------------------------
module pid_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [pid_pkg::DATA_WIDTH-1:0] req_error,
   input  logic                                  req_clear_integral,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [pid_pkg::DATA_WIDTH-1:0] rsp_drive,
   input  logic                                  rsp_saturated,
   input  logic                                  csr_write,
   input  logic [pid_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pid_pkg::DATA_WIDTH-1:0]        csr_wdata,
   output int                                    pending_count,
   output int                                    fail_count,
   output int                                    checked_count,
   output int                                    clamp_count
);

   localparam int DW = pid_pkg::DATA_WIDTH;
   localparam int AW = pid_pkg::ACC_WIDTH;
   localparam int FB = pid_pkg::FRAC_BITS;

   typedef struct packed {
      logic signed [DW-1:0] drive;
      logic                 saturated;
   } response_type;

   localparam logic signed [127:0] DRIVE_MAX = (128'sd1 <<< (DW - 1)) - 128'sd1;
   localparam logic signed [127:0] DRIVE_MIN = -(128'sd1 <<< (DW - 1));
   localparam logic signed [127:0] SUM_MAX   = (128'sd1 <<< (AW - 1)) - 128'sd1;
   localparam logic signed [127:0] SUM_MIN   = -(128'sd1 <<< (AW - 1));

   logic signed [DW-1:0] kp = '0;
   logic signed [DW-1:0] ki_dt = '0;
   logic signed [DW-1:0] kd_dt = '0;
   logic signed [DW-1:0] last_error = '0;
   logic signed [AW-1:0] error_sum = '0;

   response_type drive_queue[$];
   response_type expected;
   int           mismatches = 0;
   int           responses = 0;
   int           clamps = 0;

   function automatic response_type regulate(input logic signed [DW-1:0] err,
                                             input logic clear);
      logic signed [127:0] acc;
      logic signed [127:0] diff;
      logic signed [127:0] total;
      response_type        r;
      r.saturated = 1'b0;
      acc = err;
      if (!clear) begin
         acc = acc + error_sum;
      end
      if (acc > SUM_MAX) begin
         acc = SUM_MAX;
         r.saturated = 1'b1;
      end else if (acc < SUM_MIN) begin
         acc = SUM_MIN;
         r.saturated = 1'b1;
      end
      error_sum = acc[AW-1:0];
      diff = err;
      diff = diff - last_error;
      total = kp * err + ki_dt * error_sum + kd_dt * diff;
      total = total >>> FB;
      if (total > DRIVE_MAX) begin
         total = DRIVE_MAX;
         r.saturated = 1'b1;
      end else if (total < DRIVE_MIN) begin
         total = DRIVE_MIN;
         r.saturated = 1'b1;
      end
      r.drive = total[DW-1:0];
      last_error = err;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         kp = '0;
         ki_dt = '0;
         kd_dt = '0;
         error_sum = '0;
         last_error = '0;
         drive_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses++;
            if (rsp_saturated) begin
               clamps++;
            end
            if (drive_queue.size() == 0) begin
               mismatches++;
               $display("%0t: response with no request pending: drive %0d saturated %0b",
                        $time, rsp_drive, rsp_saturated);
            end else begin
               expected = drive_queue.pop_front();
               if (rsp_drive !== expected.drive) begin
                  mismatches++;
                  $display("%0t: drive expected %0d actual %0d",
                           $time, expected.drive, rsp_drive);
               end
               if (rsp_saturated !== expected.saturated) begin
                  mismatches++;
                  $display("%0t: saturated expected %0b actual %0b",
                           $time, expected.saturated, rsp_saturated);
               end
            end
         end
         if (csr_write) begin
            unique case (csr_index)
               pid_pkg::CSR_KP: begin
                  kp = csr_wdata;
                  error_sum = '0;
                  last_error = '0;
               end
               pid_pkg::CSR_KI_DT: begin
                  ki_dt = csr_wdata;
                  error_sum = '0;
                  last_error = '0;
               end
               pid_pkg::CSR_KD_DT: begin
                  kd_dt = csr_wdata;
                  error_sum = '0;
                  last_error = '0;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            drive_queue.push_back(regulate(req_error, req_clear_integral));
         end
      end
      pending_count <= drive_queue.size();
      fail_count <= mismatches;
      checked_count <= responses;
      clamp_count <= clamps;
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the pid regulator
// ----------------------------------------------------------------------------
// a short directed part covers error and gain extremes, the clear flag, a
// write to the unused csr index and drive clamping in both directions;
// random requests follow under several gain settings and four pacing mixes
// of sender gaps and receiver stalls, one with a long response hold-off.
// prediction and comparison live in pid_checker.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DW = pid_pkg::DATA_WIDTH;
   localparam int IW = pid_pkg::CSR_INDEX_WIDTH;

   localparam logic [IW-1:0] CSR_UNUSED = IW'(3);
   localparam logic [DW-1:0] ERR_MAX = {1'b0, {(DW - 1){1'b1}}};
   localparam logic [DW-1:0] ERR_MIN = {1'b1, {(DW - 1){1'b0}}};
   localparam logic [DW-1:0] Q_ONE   = DW'(1) << pid_pkg::FRAC_BITS;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [DW-1:0] req_error = '0;
   logic                 req_clear_integral = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [DW-1:0] rsp_drive;
   logic                 rsp_saturated;
   logic                 csr_write = 1'b0;
   logic [IW-1:0]        csr_index = pid_pkg::CSR_KP;
   logic [DW-1:0]        csr_wdata = '0;

   int   pending_count;
   int   fail_count;
   int   checked_count;
   int   clamp_count;

   int   idle_pct = 0;
   int   stall_pct = 0;
   int   requests = 0;
   int   gain_sets = 0;
   logic holding = 1'b0;
   event hold_start;

   int   idle_mix[4]  = '{0, 53, 0, 6};
   int   stall_mix[4] = '{0, 0, 53, 6};

   pid_regulator_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_error          (req_error),
      .req_clear_integral (req_clear_integral),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive          (rsp_drive),
      .rsp_saturated      (rsp_saturated),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   pid_checker check_unit (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_error          (req_error),
      .req_clear_integral (req_clear_integral),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive          (rsp_drive),
      .rsp_saturated      (rsp_saturated),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .pending_count      (pending_count),
      .fail_count         (fail_count),
      .checked_count      (checked_count),
      .clamp_count        (clamp_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holding) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // long response hold-off, counted here so the sender keeps offering
   always begin
      @(hold_start);
      holding <= 1'b1;
      repeat (300) @(posedge clock);
      holding <= 1'b0;
   end

   function automatic logic [DW-1:0] random_error();
      case ($urandom_range(0, 19)) inside
         0: return ERR_MAX;
         1: return ERR_MIN;
         2: return '0;
         3: return $urandom_range(0, 1) ? DW'(1) : '1;
         [4:8]: return DW'($urandom());
         [9:14]: return DW'($urandom_range(0, 2097152)) - DW'(1048576);
         default: return DW'($urandom_range(0, 134217728)) - DW'(67108864);
      endcase
   endfunction

   function automatic logic [DW-1:0] random_gain();
      case ($urandom_range(0, 9)) inside
         0: return ERR_MAX;
         1: return ERR_MIN;
         2: return '0;
         [3:5]: return DW'($urandom());
         default: return DW'($urandom_range(0, 524288)) - DW'(262144);
      endcase
   endfunction

   task automatic send_request(input logic [DW-1:0] err, input logic clear);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_error <= err;
      req_clear_integral <= clear;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_gains(input logic [DW-1:0] p, input logic [DW-1:0] i,
                              input logic [DW-1:0] d);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= pid_pkg::CSR_KP;
      csr_wdata <= p;
      @(posedge clock);
      csr_index <= pid_pkg::CSR_KI_DT;
      csr_wdata <= i;
      @(posedge clock);
      csr_index <= pid_pkg::CSR_KD_DT;
      csr_wdata <= d;
      @(posedge clock);
      csr_write <= 1'b0;
      gain_sets++;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unity p, quarter i, half d
      write_gains(Q_ONE, Q_ONE >> 2, Q_ONE >> 1);
      send_request('0, 1'b0);
      send_request(DW'(1), 1'b0);
      send_request('1, 1'b0);
      send_request(ERR_MAX, 1'b0);
      send_request(ERR_MIN, 1'b0);
      send_request(ERR_MAX, 1'b0);
      send_request(Q_ONE, 1'b1);
      send_request(-Q_ONE, 1'b0);

      // unused index leaves gains and state alone
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= CSR_UNUSED;
      csr_wdata <= '1;
      @(posedge clock);
      csr_write <= 1'b0;
      send_request(Q_ONE << 1, 1'b0);
      send_request(DW'(5), 1'b0);

      // drive clamps both ways
      write_gains(ERR_MAX, ERR_MAX, ERR_MAX);
      send_request(ERR_MAX, 1'b0);
      send_request(ERR_MAX, 1'b0);
      send_request(ERR_MIN, 1'b1);
      write_gains(ERR_MIN, ERR_MIN, ERR_MIN);
      send_request(ERR_MAX, 1'b0);
      send_request(ERR_MIN, 1'b0);
      send_request(DW'(12345), 1'b1);

      // zero gains
      write_gains('0, '0, '0);
      send_request(ERR_MAX, 1'b0);
      send_request(ERR_MIN, 1'b0);
      send_request(DW'(77), 1'b1);

      write_gains(-Q_ONE, DW'(1), ERR_MIN);
      repeat (3) send_request(random_error(), 1'b0);

      // random requests over the pacing mixes
      for (int p = 0; p < 4; p++) begin
         idle_pct = idle_mix[p];
         stall_pct = stall_mix[p];
         for (int c = 0; c < 4; c++) begin
            write_gains(random_gain(), random_gain(), random_gain());
            for (int n = 0; n < 64; n++) begin
               if (p == 0 && c == 0 && n == 10) begin
                  -> hold_start;
               end
               send_request(random_error(), $urandom_range(0, 11) == 0);
            end
         end
      end

      idle_pct = 0;
      stall_pct = 0;
      wait_idle();
      $display("%0d requests sent under %0d gain settings and four pacing mixes",
               requests, gain_sets);
      $display("%0d responses checked, %0d of them flagged saturated",
               checked_count, clamp_count);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d responses outstanding", pending_count);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
src/pid_pkg.sv
src/pid_regulator_unit.sv
bench/pid_checker.sv
bench/testbench.sv
